FILE: design/mfh_pkg.sv
package mfh_pkg;

    // default sizes, handed down through the top level parameters
    localparam int QUEUE_DEPTH_DEF  = 8;
    localparam int TASK_ID_BITS_DEF = 4;

    // fixed field widths of the result item
    localparam int STATUS_W = 3;
    localparam int WAIT_W   = 4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ACQUIRED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HANDOFF   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    // request type codes
    localparam logic REQ_LOCK   = 1'b0;
    localparam logic REQ_UNLOCK = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture the request and the head of the wait ring
        logic exec;    // apply the request and load the result register
    } dp_cmd_t;

endpackage

FILE: design/mfh_ctrl.sv
module mfh_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output mfh_pkg::dp_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic fire;

    // the result register may be loaded when empty or being emptied
    assign fire     = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    assign cmd.load = in_valid && in_ready;
    assign cmd.exec = fire;

    // next state and result valid flag
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a pending result that is not taken keeps the request waiting
    a_hold_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && out_valid_reg && !out_ready) |=> (state_reg == ST_EXEC))
        else $error("request left execute while result register was full");

    // a new result only appears from the execute step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result appeared without an execute step");

endmodule

FILE: design/mfh_datapath.sv
module mfh_datapath #(
    parameter int QUEUE_DEPTH  = mfh_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = mfh_pkg::TASK_ID_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mfh_pkg::dp_cmd_t              cmd,
    input  logic                          req_type,
    input  logic [TASK_ID_BITS-1:0]       task_id,
    output logic [mfh_pkg::STATUS_W-1:0]  status,
    output logic                          wake_valid,
    output logic [TASK_ID_BITS-1:0]       wake_task,
    output logic [TASK_ID_BITS-1:0]       owner_now,
    output logic                          is_free_now,
    output logic [mfh_pkg::WAIT_W-1:0]    waiting_now
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // wait ring storage
    logic [TASK_ID_BITS-1:0] ring [QUEUE_DEPTH];

    // captured request and head of ring
    logic                    unlock_reg;
    logic [TASK_ID_BITS-1:0] task_reg;
    logic [TASK_ID_BITS-1:0] head_reg;

    // mutex state
    logic                    free_reg;
    logic                    free_next;
    logic [TASK_ID_BITS-1:0] owner_reg;
    logic [TASK_ID_BITS-1:0] owner_next;
    logic [PTR_W-1:0]        wr_ptr_reg;
    logic [PTR_W-1:0]        wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [PTR_W-1:0]        rd_ptr_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    // result register
    logic [mfh_pkg::STATUS_W-1:0] status_reg;
    logic [mfh_pkg::STATUS_W-1:0] status_next;
    logic                         wake_valid_reg;
    logic                         wake_valid_next;
    logic [TASK_ID_BITS-1:0]      wake_task_reg;
    logic [TASK_ID_BITS-1:0]      wake_task_next;
    logic [CNT_W+mfh_pkg::WAIT_W-1:0] count_ext;

    logic enq;

    // request decode and next state
    always_comb
    begin
        free_next       = free_reg;
        owner_next      = owner_reg;
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        count_next      = count_reg;
        wake_valid_next = 1'b0;
        wake_task_next  = '0;
        enq             = 1'b0;
        status_next     = mfh_pkg::ST_NOT_OWNER;
        if (unlock_reg == mfh_pkg::REQ_LOCK)
        begin
            if (free_reg)
            begin
                free_next   = 1'b0;
                owner_next  = task_reg;
                status_next = mfh_pkg::ST_ACQUIRED;
            end
            else if (count_reg == CNT_FULL)
            begin
                status_next = mfh_pkg::ST_FULL;
            end
            else
            begin
                enq         = 1'b1;
                wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                count_next  = count_reg + 1'b1;
                status_next = mfh_pkg::ST_QUEUED;
            end
        end
        else
        begin
            if (owner_reg != task_reg)
            begin
                status_next = mfh_pkg::ST_NOT_OWNER;
            end
            else if (count_reg != '0)
            begin
                free_next       = 1'b0;
                owner_next      = head_reg;
                rd_ptr_next     = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
                count_next      = count_reg - 1'b1;
                wake_valid_next = 1'b1;
                wake_task_next  = head_reg;
                status_next     = mfh_pkg::ST_HANDOFF;
            end
            else
            begin
                free_next   = 1'b1;
                status_next = mfh_pkg::ST_RELEASED;
            end
        end
    end

    // ring write and registered head read
    always_ff @(posedge clk)
    begin
        if (cmd.exec && enq)
        begin
            ring[wr_ptr_reg] <= task_reg;
        end
        if (cmd.load)
        begin
            head_reg <= ring[rd_ptr_reg];
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            unlock_reg <= req_type;
            task_reg   <= task_id;
        end
        if (cmd.exec)
        begin
            status_reg    <= status_next;
            wake_task_reg <= wake_task_next;
        end
    end

    // mutex state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg       <= 1'b1;
            owner_reg      <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
            wake_valid_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            free_reg       <= free_next;
            owner_reg      <= owner_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
            wake_valid_reg <= wake_valid_next;
        end
    end

    // state after the last request is what the result reports
    assign count_ext   = {{mfh_pkg::WAIT_W{1'b0}}, count_reg};
    assign status      = status_reg;
    assign wake_valid  = wake_valid_reg;
    assign wake_task   = wake_task_reg;
    assign owner_now   = owner_reg;
    assign is_free_now = free_reg;
    assign waiting_now = count_ext[mfh_pkg::WAIT_W-1:0];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("wait count beyond queue depth");

    // nobody can wait on a free mutex
    a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg |-> (count_reg == '0))
        else $error("mutex free while tasks wait");

endmodule

FILE: design/mutex_fifo_handoff_top.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | req_type, task_id
// out     | output    | out_valid / out_ready | status, wake_valid, wake_task,
//         |           |                       | owner_now, is_free_now, waiting_now
//
// each item is captured together with the registered read of the wait ring
// head, then applied in the execute step, which loads the result register
// the next item is taken while a result waits in the result register
// a result that is not taken holds the following item in its execute cycle
// rst_n clears the mutex to free, owner 0 and an empty queue; no clearing pass
module mutex_fifo_handoff_top #(
    parameter int QUEUE_DEPTH  = mfh_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = mfh_pkg::TASK_ID_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic [TASK_ID_BITS-1:0]      task_id,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mfh_pkg::STATUS_W-1:0] status,
    output logic                         wake_valid,
    output logic [TASK_ID_BITS-1:0]      wake_task,
    output logic [TASK_ID_BITS-1:0]      owner_now,
    output logic                         is_free_now,
    output logic [mfh_pkg::WAIT_W-1:0]   waiting_now
);

    mfh_pkg::dp_cmd_t cmd;

    // sequencing of capture, execute and result handshake
    mfh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // mutex state, wait ring and result register
    mfh_datapath #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req_type),
        .task_id     (task_id),
        .status      (status),
        .wake_valid  (wake_valid),
        .wake_task   (wake_task),
        .owner_now   (owner_now),
        .is_free_now (is_free_now),
        .waiting_now (waiting_now)
    );

endmodule
